@@ sv/crr_pkg.sv @@
// shared types and constants of the can response reassembler
package crr_pkg;

  // default saturation point of the byte total
  localparam int unsigned BYTE_COUNT_MAX_DEF = 4095;

  // field widths
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned ID_W      = 29;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned TOTAL_W   = 12;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned NIB_W     = 4;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // request kinds
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FRAME = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POLL  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_APPENDED     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COMPLETE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT_DATA = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT_NONE = 2'd3;

  // command codes and limits
  localparam logic [NIB_W-1:0]   CMD_MULTI_READ = 4'hB;
  localparam logic [NIB_W-1:0]   CMD_TOUCH_READ = 4'hD;
  localparam logic [COUNT_W-1:0] LIMIT_DOWNLOAD = 8'd200;
  localparam logic [COUNT_W-1:0] LIMIT_MULTI    = 8'd5;
  localparam logic [COUNT_W-1:0] LIMIT_SINGLE   = 8'd2;
  localparam logic [LEN_W-1:0]   LEN_MAX        = 4'd8;
  localparam logic [COUNT_W-1:0] FRAMES_MAX     = 8'hFF;

  // classified request as it travels through the queue
  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [ID_W-1:0]      id;       // expected id on start, filtered frame id otherwise
    logic [COUNT_W-1:0]   count;
    logic                 remote;
    logic [LEN_W-1:0]     len;      // clamped to eight
    logic [PAYLOAD_W-1:0] payload;  // bytes at or above len cleared
  } item_t;

endpackage

@@ sv/can_response_reassembler_top.sv @@
// top level of the can response reassembler
// a request, once accepted, is registered in the queue and then in the result register before its result is valid
// throughput: one request per cycle while the result is not stalled; the back end's per-pop state update sets it
// a two-entry queue and the result register let each side stall on its own
// reset: synchronous active-low rst_n clears the wait state, the queue and result valid
module can_response_reassembler_top #(
  parameter int unsigned BYTE_COUNT_MAX = crr_pkg::BYTE_COUNT_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [crr_pkg::FUNC_W-1:0]      in_func,
  input  logic [crr_pkg::ID_W-1:0]        in_expected_id,
  input  logic [crr_pkg::COUNT_W-1:0]     in_expected_count,
  input  logic [crr_pkg::ID_W-1:0]        in_frame_id,
  input  logic                            in_frame_extended,
  input  logic                            in_frame_remote,
  input  logic [crr_pkg::LEN_W-1:0]       in_frame_len,
  input  logic [crr_pkg::PAYLOAD_W-1:0]   in_frame_payload,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [crr_pkg::STATUS_W-1:0]    out_status,
  output logic [crr_pkg::ID_W-1:0]        out_id,
  output logic [crr_pkg::LEN_W-1:0]       out_len,
  output logic [crr_pkg::PAYLOAD_W-1:0]   out_payload,
  output logic [crr_pkg::TOTAL_W-1:0]     out_byte_total,
  output logic                            out_last
);

  logic           q_full;
  logic           push;
  logic           pop;
  logic           q_valid;
  crr_pkg::item_t f_item;
  crr_pkg::item_t q_item;

  // request classification
  crr_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_expected_id    (in_expected_id),
    .in_expected_count (in_expected_count),
    .in_frame_id       (in_frame_id),
    .in_frame_extended (in_frame_extended),
    .in_frame_remote   (in_frame_remote),
    .in_frame_len      (in_frame_len),
    .in_frame_payload  (in_frame_payload),
    .q_full            (q_full),
    .push              (push),
    .item              (f_item)
  );

  // decoupling queue
  crr_queue #(
    .DEPTH (crr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wdata   (f_item),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .rdata   (q_item)
  );

  // wait tracking and results
  crr_back #(
    .BYTE_COUNT_MAX (BYTE_COUNT_MAX)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .item           (q_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_id         (out_id),
    .out_len        (out_len),
    .out_payload    (out_payload),
    .out_byte_total (out_byte_total),
    .out_last       (out_last)
  );

endmodule

@@ sv/crr_front.sv @@
// front end: accepts requests, clamps and masks frames, drops requests of kind none
module crr_front (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [crr_pkg::FUNC_W-1:0]      in_func,
  input  logic [crr_pkg::ID_W-1:0]        in_expected_id,
  input  logic [crr_pkg::COUNT_W-1:0]     in_expected_count,
  input  logic [crr_pkg::ID_W-1:0]        in_frame_id,
  input  logic                            in_frame_extended,
  input  logic                            in_frame_remote,
  input  logic [crr_pkg::LEN_W-1:0]       in_frame_len,
  input  logic [crr_pkg::PAYLOAD_W-1:0]   in_frame_payload,
  input  logic                            q_full,
  output logic                            push,
  output crr_pkg::item_t                  item
);

  logic [crr_pkg::LEN_W-1:0]     len_c;
  logic [crr_pkg::PAYLOAD_W-1:0] pay_m;
  logic [crr_pkg::ID_W-1:0]      fid;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && (in_func != crr_pkg::FUNC_NONE);

  // length clamp and byte mask
  always_comb begin
    len_c = (in_frame_len > crr_pkg::LEN_MAX) ? crr_pkg::LEN_MAX : in_frame_len;
    for (int i = 0; i < 8; i++) begin
      pay_m[i*8 +: 8] = (4'(i) < len_c) ? in_frame_payload[i*8 +: 8] : 8'h00;
    end
  end

  // standard ids keep the low eleven bits
  assign fid = in_frame_extended ? in_frame_id : {18'h0, in_frame_id[10:0]};

  always_comb begin
    item.func    = in_func;
    item.id      = (in_func == crr_pkg::FUNC_START) ? in_expected_id : fid;
    item.count   = in_expected_count;
    item.remote  = in_frame_remote;
    item.len     = len_c;
    item.payload = pay_m;
  end

endmodule

@@ sv/crr_queue.sv @@
// short fifo between front and back
module crr_queue #(
  parameter int unsigned DEPTH = crr_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  crr_pkg::item_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output crr_pkg::item_t rdata
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  crr_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt;
  logic [PW-1:0]  rptr_r, rptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign rdata   = mem_r[rptr_r];

  // pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

@@ sv/crr_back.sv @@
// back end: wait state, filtering, completion and timeout, result register
module crr_back #(
  parameter int unsigned BYTE_COUNT_MAX = crr_pkg::BYTE_COUNT_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  crr_pkg::item_t                  item,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [crr_pkg::STATUS_W-1:0]    out_status,
  output logic [crr_pkg::ID_W-1:0]        out_id,
  output logic [crr_pkg::LEN_W-1:0]       out_len,
  output logic [crr_pkg::PAYLOAD_W-1:0]   out_payload,
  output logic [crr_pkg::TOTAL_W-1:0]     out_byte_total,
  output logic                            out_last
);

  localparam int unsigned BW = $clog2(BYTE_COUNT_MAX + 1);

  // wait state
  logic                          waiting_r, waiting_nxt;
  logic [crr_pkg::ID_W-1:0]      want_id_r, want_id_nxt;
  logic [crr_pkg::COUNT_W-1:0]   want_count_r, want_count_nxt;
  logic [crr_pkg::COUNT_W-1:0]   attempts_r, attempts_nxt;
  logic [crr_pkg::COUNT_W-1:0]   frames_r, frames_nxt;
  logic [crr_pkg::NIB_W-1:0]     htotal_r, htotal_nxt;
  logic                          hlatched_r, hlatched_nxt;
  logic [BW-1:0]                 bytes_r, bytes_nxt;

  // result register
  logic                          ovalid_r, ovalid_nxt;
  logic [crr_pkg::STATUS_W-1:0]  ostatus_r;
  logic [crr_pkg::ID_W-1:0]      oid_r;
  logic [crr_pkg::LEN_W-1:0]     olen_r;
  logic [crr_pkg::PAYLOAD_W-1:0] opay_r;
  logic [crr_pkg::TOTAL_W-1:0]   ototal_r;
  logic                          olast_r;

  // per-request decision
  logic                          res;
  logic [crr_pkg::STATUS_W-1:0]  res_status;
  logic [crr_pkg::ID_W-1:0]      res_id;
  logic [crr_pkg::LEN_W-1:0]     fwd_len;
  logic [crr_pkg::PAYLOAD_W-1:0] fwd_pay;
  logic                          res_last;

  logic [crr_pkg::NIB_W-1:0]     cmd;
  logic                          multi;
  logic                          match;
  logic                          done;
  logic                          tmo;
  logic [crr_pkg::COUNT_W-1:0]   limit;
  logic [crr_pkg::NIB_W-1:0]     tot;
  logic [crr_pkg::NIB_W-1:0]     seq;
  logic [crr_pkg::NIB_W-1:0]     ht;
  logic [BW:0]                   bsum;

  assign pop = q_valid && (!ovalid_r || out_ready);

  // mode and attempt limit of the open wait
  always_comb begin
    cmd   = want_id_r[6:3];
    multi = (want_id_r != '0) &&
            ((cmd == crr_pkg::CMD_MULTI_READ) || (cmd == crr_pkg::CMD_TOUCH_READ));
    if (want_id_r == '0) begin
      limit = crr_pkg::LIMIT_DOWNLOAD;
    end else if ((want_count_r > 8'd1) || (cmd == crr_pkg::CMD_MULTI_READ) ||
                 (cmd == crr_pkg::CMD_TOUCH_READ)) begin
      limit = crr_pkg::LIMIT_MULTI;
    end else begin
      limit = crr_pkg::LIMIT_SINGLE;
    end
  end

  // frame handling and next state
  always_comb begin
    waiting_nxt    = waiting_r;
    want_id_nxt    = want_id_r;
    want_count_nxt = want_count_r;
    attempts_nxt   = attempts_r;
    frames_nxt     = frames_r;
    htotal_nxt     = htotal_r;
    hlatched_nxt   = hlatched_r;
    bytes_nxt      = bytes_r;
    res            = 1'b0;
    res_status     = crr_pkg::ST_APPENDED;
    res_id         = item.id;
    res_last       = 1'b0;
    done           = 1'b0;
    tmo            = 1'b0;
    tot            = item.payload[7:4];
    seq            = item.payload[3:0];
    ht             = hlatched_r ? htotal_r : tot;
    bsum           = '0;
    match          = (item.func == crr_pkg::FUNC_FRAME) && !item.remote &&
                     ((want_id_r == '0) || (item.id == want_id_r));
    fwd_len        = match ? item.len : '0;
    fwd_pay        = match ? item.payload : '0;

    if (item.func == crr_pkg::FUNC_START) begin
      waiting_nxt    = 1'b1;
      want_id_nxt    = item.id;
      want_count_nxt = item.count;
      attempts_nxt   = '0;
      frames_nxt     = '0;
      htotal_nxt     = '0;
      hlatched_nxt   = 1'b0;
      bytes_nxt      = '0;
    end else if (waiting_r) begin
      attempts_nxt = attempts_r + 1'b1;
      if (match) begin
        // saturating byte and frame counts
        bsum = {1'b0, bytes_r} + (BW + 1)'(item.len);
        bytes_nxt = (bsum > (BW + 1)'(BYTE_COUNT_MAX)) ? BW'(BYTE_COUNT_MAX) : bsum[BW-1:0];
        if (frames_r < crr_pkg::FRAMES_MAX) begin
          frames_nxt = frames_r + 1'b1;
        end
        // completion by mode
        if (multi && (cmd == crr_pkg::CMD_MULTI_READ) && (item.len >= 4'd2)) begin
          done = item.payload[15];
        end else if (multi && (cmd == crr_pkg::CMD_TOUCH_READ) && (item.len != '0) &&
                     (tot != '0) && (seq != '0)) begin
          hlatched_nxt = 1'b1;
          htotal_nxt   = ht;
          done         = (frames_nxt >= {4'h0, ht});
        end else begin
          done = ((want_count_r <= 8'd1) && !multi) ||
                 ((want_count_r > 8'd1) && (frames_nxt >= want_count_r));
        end
      end
      tmo = (attempts_nxt >= limit);
      if (done) begin
        waiting_nxt = 1'b0;
        res         = 1'b1;
        res_status  = crr_pkg::ST_COMPLETE;
        res_last    = 1'b1;
      end else if (tmo) begin
        waiting_nxt = 1'b0;
        res         = 1'b1;
        res_status  = (bytes_nxt != '0) ? crr_pkg::ST_TIMEOUT_DATA : crr_pkg::ST_TIMEOUT_NONE;
        res_id      = want_id_r;
        res_last    = 1'b1;
      end else if (match) begin
        res = 1'b1;
      end
    end
  end

  // result valid
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (pop) begin
      ovalid_nxt = res;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r    <= 1'b0;
      want_id_r    <= '0;
      want_count_r <= '0;
      attempts_r   <= '0;
      frames_r     <= '0;
      htotal_r     <= '0;
      hlatched_r   <= 1'b0;
      bytes_r      <= '0;
      ovalid_r     <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (pop) begin
        waiting_r    <= waiting_nxt;
        want_id_r    <= want_id_nxt;
        want_count_r <= want_count_nxt;
        attempts_r   <= attempts_nxt;
        frames_r     <= frames_nxt;
        htotal_r     <= htotal_nxt;
        hlatched_r   <= hlatched_nxt;
        bytes_r      <= bytes_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop && res) begin
      ostatus_r <= res_status;
      oid_r     <= res_id;
      olen_r    <= fwd_len;
      opay_r    <= fwd_pay;
      ototal_r  <= crr_pkg::TOTAL_W'(bytes_nxt);
      olast_r   <= res_last;
    end
  end

  assign out_valid      = ovalid_r;
  assign out_status     = ostatus_r;
  assign out_id         = oid_r;
  assign out_len        = olen_r;
  assign out_payload    = opay_r;
  assign out_byte_total = ototal_r;
  assign out_last       = olast_r;

endmodule

@@ sv/crr_checker.sv @@
// port-level checks of the can response reassembler and their bind
module crr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [crr_pkg::STATUS_W-1:0]    out_status,
  input logic [crr_pkg::LEN_W-1:0]       out_len,
  input logic [crr_pkg::PAYLOAD_W-1:0]   out_payload,
  input logic [crr_pkg::TOTAL_W-1:0]     out_byte_total,
  input logic                            out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload) && $stable(out_status))
    else $error("result changed while stalled");

  // only an appended frame leaves the wait open
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_status != crr_pkg::ST_APPENDED)))
    else $error("last flag disagrees with status");

  // an empty timeout has no accumulated bytes
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == crr_pkg::ST_TIMEOUT_NONE) |-> (out_byte_total == '0))
    else $error("empty timeout with bytes");

  // forwarded length never exceeds a classic frame
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_len <= crr_pkg::LEN_MAX))
    else $error("forwarded length too large");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind can_response_reassembler_top crr_checker u_crr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_len        (out_len),
  .out_payload    (out_payload),
  .out_byte_total (out_byte_total),
  .out_last       (out_last)
);
